FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file u8san_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define U8SAN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define U8SAN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, active through reset.
`define U8SAN_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/u8san_pkg.sv
// ---------------------------------------------------------------------------
// u8san_pkg
// Types, constants and decode functions for the UTF-8 sanitizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8san_pkg;

  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned IDX_W     = 2;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [CNT_W-1:0] REPL_LEN = 3'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       run_last;
    logic       text_end;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic seq_ready;
    logic out_free;
    logic grp_last;
  } sts_t;

  function automatic logic [CNT_W-1:0] seq_len(input logic [7:0] lead);
    logic [CNT_W-1:0] len;
    if (lead > 8'hEF) begin
      len = 3'd4;
    end else if (lead > 8'hDF) begin
      len = 3'd3;
    end else if (lead > 8'hBF) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  function automatic logic seq_valid(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input logic [CNT_W-1:0] len);
    logic [21:0] cp;
    logic        ok;
    cp = '0;
    ok = 1'b0;
    case (len)
      3'd1: begin
        ok = b0 <= 8'h7F;
      end
      3'd2: begin
        cp = {11'd0, b0[4:0], b1[5:0]};
        ok = is_cont(b1) && (cp > 22'h7F);
      end
      3'd3: begin
        cp = {6'd0, b0[3:0], b1[5:0], b2[5:0]};
        ok = is_cont(b1) && is_cont(b2) && (cp > 22'h7FF) &&
             ((cp < 22'hD800) || (cp > 22'hDFFF));
      end
      3'd4: begin
        cp = {b0[3:0], b1[5:0], b2[5:0], b3[5:0]};
        ok = is_cont(b1) && is_cont(b2) && is_cont(b3) &&
             (cp > 22'hFFFF) && (cp < 22'h110000);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    return ok;
  endfunction

endpackage

FILE: hw/rtl/u8san_ctrl.sv
// ---------------------------------------------------------------------------
// u8san_ctrl
// Sequencer: accepts a word, scans buffered sequences, paces output bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8san_ctrl import u8san_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_nxt = sts.seq_ready ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.grp_last) begin
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.take = sts.seq_ready;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/u8san_dpath.sv
// ---------------------------------------------------------------------------
// u8san_dpath
// Byte buffer, sequence check, group register and output word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8san_dpath import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic [7:0]       wbuf_r   [BUF_DEPTH];
  logic [7:0]       wbuf_nxt [BUF_DEPTH];
  logic [CNT_W-1:0] wcnt_r;
  logic [CNT_W-1:0] wcnt_nxt;
  logic             fin_r;
  logic [7:0]       grp_r    [BUF_DEPTH];
  logic [CNT_W-1:0] glen_r;
  logic             repl_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  out_word_t        out_data_r;
  out_word_t        out_data_nxt;

  logic [CNT_W-1:0] hlen;
  logic             have;
  logic             seq_ok;
  logic             seq_ready;
  logic [CNT_W-1:0] shamt;
  logic             grp_last;
  logic [7:0]       emit_byte;

  assign hlen      = seq_len(wbuf_r[0]);
  assign have      = wcnt_r >= hlen;
  assign seq_ok    = have && seq_valid(wbuf_r[0], wbuf_r[1], wbuf_r[2], wbuf_r[3], hlen);
  assign seq_ready = (wcnt_r != '0) && (have || fin_r);
  assign shamt     = seq_ok ? hlen : 3'd1;
  assign grp_last  = idx_r == IDX_W'(glen_r - 3'd1);

  always_comb begin
    logic [CNT_W-1:0] src;
    src = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      wbuf_nxt[i] = wbuf_r[i];
    end
    wcnt_nxt = wcnt_r;
    if (cmd.load) begin
      wbuf_nxt[wcnt_r[IDX_W-1:0]] = in_data.in_byte;
      wcnt_nxt = wcnt_r + 3'd1;
    end else if (cmd.take) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        src = CNT_W'(i) + shamt;
        wbuf_nxt[i] = (src < CNT_W'(BUF_DEPTH)) ? wbuf_r[src[IDX_W-1:0]] : 8'h00;
      end
      wcnt_nxt = wcnt_r - shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
      fin_r  <= 1'b0;
      idx_r  <= '0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        wbuf_r[i] <= 8'h00;
      end
    end else begin
      wcnt_r <= wcnt_nxt;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        wbuf_r[i] <= wbuf_nxt[i];
      end
      if (cmd.load) begin
        fin_r <= in_data.is_final;
      end
      if (cmd.take) begin
        idx_r <= '0;
      end else if (cmd.emit) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        grp_r[i] <= wbuf_r[i];
      end
      glen_r <= seq_ok ? hlen : REPL_LEN;
      repl_r <= !seq_ok;
    end
  end

  always_comb begin
    emit_byte = grp_r[idx_r];
    if (repl_r) begin
      case (idx_r)
        2'd0:    emit_byte = REPL_B0;
        2'd1:    emit_byte = REPL_B1;
        default: emit_byte = REPL_B2;
      endcase
    end
    out_data_nxt.out_byte       = emit_byte;
    out_data_nxt.is_replacement = repl_r;
    out_data_nxt.run_last       = grp_last && !seq_ready;
    out_data_nxt.text_end       = grp_last && !seq_ready && fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.seq_ready = seq_ready;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.grp_last  = grp_last;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

FILE: hw/rtl/utf8_sanitizer_top.sv
// ---------------------------------------------------------------------------
// utf8_sanitizer_top
// Streaming UTF-8 validator that replaces bad sequences with U+FFFD.
// ---------------------------------------------------------------------------
// One input word is taken at a time. After it is accepted, each sequence
// found in the buffer is scanned and then sent as output bytes (1 to 4 for
// a valid sequence, 3 for EF BF BD), and a final scan ends the word. The
// sequencer in u8san_ctrl sets this pace; output backpressure holds it in
// place. Up to three bytes of an incomplete sequence are held between words
// and flushed on is_final.
`timescale 1ns / 1ps

module utf8_sanitizer_top import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  cmd_t cmd;
  sts_t sts;

  u8san_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8san_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/u8san_checker.sv
// ---------------------------------------------------------------------------
// u8san_checker
// Port-level checks on the sanitizer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8san_checker import u8san_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  `U8SAN_ASSERT_NXT_ALWAYS(a_rst_clears_out, clk, !rst_n, !out_valid)
  `U8SAN_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid && out_data.text_end, out_data.run_last)
  `U8SAN_ASSERT_IMP(a_repl_bytes, clk, rst_n, out_valid && out_data.is_replacement, (out_data.out_byte == REPL_B0) || (out_data.out_byte == REPL_B1) || (out_data.out_byte == REPL_B2))
  `U8SAN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind utf8_sanitizer_top u8san_checker u_chk (.*);

FILE: tb/utf8_sanitizer_top_tb.sv
// ---------------------------------------------------------------------------
// utf8_sanitizer_top_tb
// Self-checking bench for the streaming UTF-8 sanitizer.
// ---------------------------------------------------------------------------
// A clocked driver offers raw bytes from a queue that is filled at time zero.
// The queue holds a directed set of edge cases and then random text: mostly
// well-formed characters, with some truncated, corrupted and random bytes.
// Each accepted byte goes through a local sanitizer model, which queues the
// output words it should cause. A clocked monitor checks every output word
// against the oldest queued one. Both sides insert random gaps. Once, the
// receiver holds off for a long stretch, and the sender pauses at least twice
// until all queued words have drained.
`timescale 1ns / 1ps

module utf8_sanitizer_top_tb;
  import u8san_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RAND_ITEMS    = 85;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_AT       = 60;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct packed {
    in_word_t   w;
    logic [7:0] gap;
    logic       drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  stim_t       stim_q[$];
  out_word_t   sanitized_q[$];
  logic [7:0]  held_bytes [0:2];
  int unsigned held_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned got_cnt = 0;
  logic        quiet = 1'b0;
  logic        drain_next = 1'b0;

  utf8_sanitizer_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- sanitizer model ----------------

  function automatic int unsigned lead_len(input logic [7:0] b);
    if (b > 8'hEF) return 4;
    if (b > 8'hDF) return 3;
    if (b > 8'hBF) return 2;
    return 1;
  endfunction

  function automatic logic cont_byte(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic seq_legal(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input int unsigned len);
    int unsigned cp;
    case (len)
      1: begin
        return b0 <= 8'h7F;
      end
      2: begin
        cp = 32'({b0[4:0], b1[5:0]});
        return cont_byte(b1) && cp > 32'h7F;
      end
      3: begin
        cp = 32'({b0[3:0], b1[5:0], b2[5:0]});
        return cont_byte(b1) && cont_byte(b2) && cp > 32'h7FF &&
               (cp < 32'hD800 || cp > 32'hDFFF);
      end
      default: begin
        cp = 32'({b0[3:0], b1[5:0], b2[5:0], b3[5:0]});
        return cont_byte(b1) && cont_byte(b2) && cont_byte(b3) &&
               cp > 32'hFFFF && cp < 32'h110000;
      end
    endcase
  endfunction

  function automatic void emit_byte(input logic [7:0] b, input logic repl);
    out_word_t r;
    r.out_byte       = b;
    r.is_replacement = repl;
    r.run_last       = 1'b0;
    r.text_end       = 1'b0;
    sanitized_q.insert(sanitized_q.size(), r);
  endfunction

  function automatic void sanitize_byte(input in_word_t w);
    logic [7:0]  scan_b [0:6];
    int unsigned n;
    int unsigned pos;
    int unsigned len;
    int unsigned first;
    out_word_t   r;
    for (int i = 0; i < 7; i++) scan_b[i] = 8'h00;
    first = sanitized_q.size();
    n = held_cnt;
    for (int i = 0; i < n; i++) scan_b[i] = held_bytes[i];
    scan_b[n] = w.in_byte;
    n = n + 1;
    pos = 0;
    while (pos < n) begin
      len = lead_len(scan_b[pos]);
      if (n - pos < len && !w.is_final) break;
      if (n - pos >= len &&
          seq_legal(scan_b[pos], scan_b[pos+1], scan_b[pos+2], scan_b[pos+3], len)) begin
        for (int i = 0; i < len; i++) emit_byte(scan_b[pos+i], 1'b0);
        pos = pos + len;
      end else begin
        emit_byte(REPL_B0, 1'b1);
        emit_byte(REPL_B1, 1'b1);
        emit_byte(REPL_B2, 1'b1);
        pos = pos + 1;
      end
    end
    held_cnt = n - pos;
    for (int i = 0; i < 3; i++) held_bytes[i] = (i < held_cnt) ? scan_b[pos+i] : 8'h00;
    if (sanitized_q.size() > first) begin
      r = sanitized_q[sanitized_q.size() - 1];
      r.run_last = 1'b1;
      r.text_end = w.is_final;
      sanitized_q[sanitized_q.size() - 1] = r;
    end
  endfunction

  // ---------------- stimulus ----------------

  task automatic push_byte(input logic [7:0] b, input logic fin);
    stim_t s;
    s.w.in_byte  = b;
    s.w.is_final = fin;
    s.drain      = drain_next;
    drain_next   = 1'b0;
    if (quiet) begin
      s.gap = 8'd0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: s.gap = 8'($urandom_range(1, 3));
        5:             s.gap = 8'($urandom_range(10, 40));
        default:       s.gap = 8'd0;
      endcase
    end
    stim_q.insert(stim_q.size(), s);
  endtask

  initial begin
    int unsigned n_rand;
    int unsigned kind;
    int unsigned len;
    int unsigned nb;
    logic [20:0] cp;
    logic [7:0]  seq [0:3];
    logic        fin;

    for (int i = 0; i < 3; i++) held_bytes[i] = 8'h00;

    // edge cases, no idling
    quiet = 1'b1;
    push_byte(8'h00, 1'b0); push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hC0, 1'b0); push_byte(8'hAF, 1'b0);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hE0, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
    push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
    push_byte(8'hC3, 1'b1);

    // random text
    drain_next = 1'b1;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      quiet = ((n_rand / 25) % 4) == 3;
      if (n_rand >= 70 && n_rand < 74) drain_next = 1'b1;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      case (len)
        1: cp = 21'($urandom_range(0, 32'h7F));
        2: cp = 21'($urandom_range(32'h80, 32'h7FF));
        3: begin
          cp = 21'($urandom_range(32'h800, 32'hFFFF));
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h8000;
        end
        default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
      endcase
      case (len)
        1: seq[0] = cp[7:0];
        2: begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
        end
        3: begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
        end
        default: begin
          seq[0] = {5'b11110, cp[20:18]};
          seq[1] = {2'b10, cp[17:12]};
          seq[2] = {2'b10, cp[11:6]};
          seq[3] = {2'b10, cp[5:0]};
        end
      endcase
      nb = len;
      if (kind == 6) begin
        seq[0] = 8'($urandom_range(0, 255));
        nb = 1;
      end else if (kind == 7 && len > 1) begin
        nb = $urandom_range(1, len - 1);
      end else if (kind == 8 && len > 1) begin
        seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 9) begin
        nb = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) seq[i] = 8'($urandom_range(0, 255));
      end
      fin = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < nb; i++) push_byte(seq[i], fin && (i == nb - 1));
      n_rand = n_rand + nb;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && sanitized_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------- driver ----------------

  int unsigned gap_left = 0;

  always @(posedge clk) begin
    logic     nxt_valid;
    in_word_t nxt_data;
    stim_t    s;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sanitize_byte(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain && sanitized_q.size() != 0)) begin
          s = stim_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = s.w;
          if (stim_q.size() != 0) gap_left = stim_q[0].gap;
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // ---------------- monitor ----------------

  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    logic      nxt_stall;
    out_word_t want;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_cnt = got_cnt + 1;
        if (sanitized_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("unexpected word: byte=%h repl=%b last=%b end=%b",
                     out_data.out_byte, out_data.is_replacement,
                     out_data.run_last, out_data.text_end);
          err_cnt = err_cnt + 1;
        end else begin
          want = sanitized_q.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.is_replacement !== want.is_replacement ||
              out_data.run_last !== want.run_last ||
              out_data.text_end !== want.text_end) begin
            if (err_cnt < MAX_REPORTS)
              $display("word %0d: exp %h/%b/%b/%b, got %h/%b/%b/%b",
                       got_cnt, want.out_byte, want.is_replacement, want.run_last,
                       want.text_end, out_data.out_byte, out_data.is_replacement,
                       out_data.run_last, out_data.text_end);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        nxt_stall = 1'b1;
      end else if (!hold_done && got_cnt >= HOLD_AT) begin
        // long back-pressure so the input side fills and stalls
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        nxt_stall = 1'b1;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        nxt_stall = 1'b1;
      end else if (((got_cnt / 40) % 3) == 1 && $urandom_range(0, 3) == 0 ||
                   ((got_cnt / 40) % 3) == 2 && $urandom_range(0, 1) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
                                                 : $urandom_range(0, 2);
        nxt_stall = 1'b1;
      end
    end
    out_stall <= nxt_stall;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/u8san_pkg.sv
hw/rtl/u8san_ctrl.sv
hw/rtl/u8san_dpath.sv
hw/rtl/utf8_sanitizer_top.sv
hw/rtl/u8san_checker.sv
tb/utf8_sanitizer_top_tb.sv
